### design/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg: shared types and codes of the line rasterizer
// action codes, color width and the control structs that pass between stages
// ----------------------------------------------------------------------------
package blr_pkg;

    localparam int COLOR_BITS = 16;

    // action field codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // control of the word held in the input register
    typedef struct packed {
        logic valid;
        logic action;
    } in_ctrl_t;

    // status of the walker toward the result register
    typedef struct packed {
        logic valid;   // a pixel comes out of this word
        logic last;    // pixel is the line's end point
        logic active;  // a line is in progress
    } walk_stat_t;

endpackage

### design/blr_in_stage.sv
// ----------------------------------------------------------------------------
// blr_in_stage: input register of the line rasterizer
// captures one word from the input channel, holds it while the walker stalls
// ----------------------------------------------------------------------------
module blr_in_stage #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         action,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic                         advance,
    output blr_pkg::in_ctrl_t            s1_ctrl,
    output logic signed [COORD_BITS-1:0] s1_x_start,
    output logic signed [COORD_BITS-1:0] s1_y_start,
    output logic signed [COORD_BITS-1:0] s1_x_end,
    output logic signed [COORD_BITS-1:0] s1_y_end
);

    logic                         valid_reg;
    logic                         valid_next;
    logic                         action_reg;
    logic signed [COORD_BITS-1:0] xs_reg;
    logic signed [COORD_BITS-1:0] ys_reg;
    logic signed [COORD_BITS-1:0] xe_reg;
    logic signed [COORD_BITS-1:0] ye_reg;
    logic                         take;

    // free when empty or when the held word moves on this cycle
    assign in_ready = !valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            action_reg <= action;
            xs_reg     <= x_start;
            ys_reg     <= y_start;
            xe_reg     <= x_end;
            ye_reg     <= y_end;
        end
    end

    assign s1_ctrl.valid  = valid_reg;
    assign s1_ctrl.action = action_reg;
    assign s1_x_start     = xs_reg;
    assign s1_y_start     = ys_reg;
    assign s1_x_end       = xe_reg;
    assign s1_y_end       = ye_reg;

endmodule

### design/blr_walk.sv
// ----------------------------------------------------------------------------
// blr_walk: line setup and Bresenham walker
// holds the line state, sets it up on load, emits and advances on step
// ----------------------------------------------------------------------------
module blr_walk #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  blr_pkg::in_ctrl_t            s1_ctrl,
    input  logic signed [COORD_BITS-1:0] s1_x_start,
    input  logic signed [COORD_BITS-1:0] s1_y_start,
    input  logic signed [COORD_BITS-1:0] s1_x_end,
    input  logic signed [COORD_BITS-1:0] s1_y_end,
    input  logic                         advance,
    output blr_pkg::walk_stat_t          stat,
    output logic signed [COORD_BITS-1:0] res_x,
    output logic signed [COORD_BITS-1:0] res_y
);

    localparam int DB = COORD_BITS + 1;  // coordinate difference
    localparam int EB = COORD_BITS + 2;  // error term
    localparam int TB = COORD_BITS + 3;  // doubled error and compares

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] tgt_x_reg, tgt_x_next;
    logic signed [COORD_BITS-1:0] tgt_y_reg, tgt_y_next;
    logic        [COORD_BITS-1:0] span_x_reg, span_x_next;
    logic        [COORD_BITS-1:0] span_y_reg, span_y_next;
    logic                         neg_x_reg, neg_x_next;
    logic                         neg_y_reg, neg_y_next;
    logic signed [EB-1:0]         err_reg, err_next;
    logic                         active_reg, active_next;

    logic                         fire;
    logic signed [COORD_BITS-1:0] ax, ay, bx, by;
    logic signed [DB-1:0]         dx, dy;
    logic        [DB-1:0]         adx, ady;
    logic                         done;
    logic signed [TB-1:0]         e2;
    logic signed [TB-1:0]         sx_t, sy_t;
    logic signed [TB-1:0]         err_sum;
    logic                         move_x, move_y;

    assign fire = s1_ctrl.valid && advance;

    // load: order the endpoints of a horizontal or vertical line so pixels ascend
    always_comb
    begin
        ax = s1_x_start;
        ay = s1_y_start;
        bx = s1_x_end;
        by = s1_y_end;
        if (s1_y_start == s1_y_end)
        begin
            if (s1_x_start > s1_x_end)
            begin
                ax = s1_x_end;
                bx = s1_x_start;
            end
        end
        else if (s1_x_start == s1_x_end)
        begin
            if (s1_y_start > s1_y_end)
            begin
                ay = s1_y_end;
                by = s1_y_start;
            end
        end
    end

    assign dx  = DB'(bx) - DB'(ax);
    assign dy  = DB'(by) - DB'(ay);
    assign adx = dx[DB-1] ? DB'(-dx) : DB'(dx);
    assign ady = dy[DB-1] ? DB'(-dy) : DB'(dy);

    // step: error update
    assign done    = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);
    assign e2      = TB'(err_reg) <<< 1;
    assign sx_t    = $signed(TB'(span_x_reg));
    assign sy_t    = $signed(TB'(span_y_reg));
    assign move_x  = e2 > -sy_t;
    assign move_y  = e2 < sx_t;
    assign err_sum = TB'(err_reg) - (move_x ? sy_t : TB'(0)) + (move_y ? sx_t : TB'(0));

    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        tgt_x_next  = tgt_x_reg;
        tgt_y_next  = tgt_y_reg;
        span_x_next = span_x_reg;
        span_y_next = span_y_reg;
        neg_x_next  = neg_x_reg;
        neg_y_next  = neg_y_reg;
        err_next    = err_reg;
        active_next = active_reg;
        if (fire)
        begin
            if (s1_ctrl.action == blr_pkg::ACT_LOAD)
            begin
                cur_x_next  = ax;
                cur_y_next  = ay;
                tgt_x_next  = bx;
                tgt_y_next  = by;
                span_x_next = adx[COORD_BITS-1:0];
                span_y_next = ady[COORD_BITS-1:0];
                neg_x_next  = !(ax < bx);
                neg_y_next  = !(ay < by);
                err_next    = EB'(adx) - EB'(ady);
                active_next = 1'b1;
            end
            else if (active_reg)
            begin
                if (done)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    err_next = err_sum[EB-1:0];
                    if (move_x)
                    begin
                        cur_x_next = neg_x_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                    end
                    if (move_y)
                    begin
                        cur_y_next = neg_y_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            tgt_x_reg  <= '0;
            tgt_y_reg  <= '0;
            span_x_reg <= '0;
            span_y_reg <= '0;
            neg_x_reg  <= 1'b0;
            neg_y_reg  <= 1'b0;
            err_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            tgt_x_reg  <= tgt_x_next;
            tgt_y_reg  <= tgt_y_next;
            span_x_reg <= span_x_next;
            span_y_reg <= span_y_next;
            neg_x_reg  <= neg_x_next;
            neg_y_reg  <= neg_y_next;
            err_reg    <= err_next;
            active_reg <= active_next;
        end
    end

    assign stat.valid  = s1_ctrl.valid && (s1_ctrl.action == blr_pkg::ACT_STEP) && active_reg;
    assign stat.last   = done;
    assign stat.active = active_reg;
    assign res_x       = cur_x_reg;
    assign res_y       = cur_y_reg;

endmodule

### design/bresenham_line_raster.sv
// ----------------------------------------------------------------------------
// bresenham_line_raster: integer line rasterizer, one pixel per step word
// load sets up a line between two endpoints, each step emits the next pixel
// ----------------------------------------------------------------------------
//
//  channel   signals                                   direction   width
//  -------   ---------------------------------------   ---------   -------------
//  input     in_valid/in_ready, action, x/y start/end   in          1 + 4*COORD
//  output    out_valid/out_ready, pixel_x/y, color,     out         2*COORD + 17
//            last_pixel
//  config    cfg_we, cfg_wdata (draw_color)            in          16
//
//  one word per clock while the output is not stalled; a word is held in the input
//  register and its pixel is then registered in the result register
//  the combinational error add and compare in the walker sets this rate
//  reset clears the line state to idle and draw_color to zero
//  a stalled output holds the result register and the input register together;
//  the input accepts again as soon as the result is taken
//
module bresenham_line_raster #(
    parameter int COORD_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [blr_pkg::COLOR_BITS-1:0]      cfg_wdata,
    // input words
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic signed [COORD_BITS-1:0]        x_start,
    input  logic signed [COORD_BITS-1:0]        y_start,
    input  logic signed [COORD_BITS-1:0]        x_end,
    input  logic signed [COORD_BITS-1:0]        y_end,
    // pixel words
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [COORD_BITS-1:0]        pixel_x,
    output logic signed [COORD_BITS-1:0]        pixel_y,
    output logic [blr_pkg::COLOR_BITS-1:0]      pixel_color,
    output logic                                last_pixel
);

    // draw color register
    logic [blr_pkg::COLOR_BITS-1:0] color_reg;

    // input register outputs
    blr_pkg::in_ctrl_t              s1_ctrl;
    logic signed [COORD_BITS-1:0]   s1_x_start;
    logic signed [COORD_BITS-1:0]   s1_y_start;
    logic signed [COORD_BITS-1:0]   s1_x_end;
    logic signed [COORD_BITS-1:0]   s1_y_end;

    // walker results
    blr_pkg::walk_stat_t            stat;
    logic signed [COORD_BITS-1:0]   res_x;
    logic signed [COORD_BITS-1:0]   res_y;

    // result register
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [COORD_BITS-1:0]   px_reg;
    logic signed [COORD_BITS-1:0]   py_reg;
    logic [blr_pkg::COLOR_BITS-1:0] pc_reg;
    logic                           last_reg;

    // the held word moves when the result register is empty or being drained
    logic                           advance;

    assign advance = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= '0;
        end
        else if (cfg_we)
        begin
            color_reg <= cfg_wdata;
        end
    end

    blr_in_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .advance    (advance),
        .s1_ctrl    (s1_ctrl),
        .s1_x_start (s1_x_start),
        .s1_y_start (s1_y_start),
        .s1_x_end   (s1_x_end),
        .s1_y_end   (s1_y_end)
    );

    blr_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_ctrl    (s1_ctrl),
        .s1_x_start (s1_x_start),
        .s1_y_start (s1_y_start),
        .s1_x_end   (s1_x_end),
        .s1_y_end   (s1_y_end),
        .advance    (advance),
        .stat       (stat),
        .res_x      (res_x),
        .res_y      (res_y)
    );

    // loads and idle steps leave the result register empty
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = stat.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // color is sampled at the step, as the pixel leaves the walker
    always_ff @(posedge clk)
    begin
        if (advance && stat.valid)
        begin
            px_reg   <= res_x;
            py_reg   <= res_y;
            pc_reg   <= color_reg;
            last_reg <= stat.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_color = pc_reg;
    assign last_pixel  = last_reg;

    // a processed load always starts a line
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_ctrl.valid && advance && s1_ctrl.action == blr_pkg::ACT_LOAD)
        |=> stat.active)
        else $error("load did not start a line");

    // the end point pixel closes the line
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stat.valid && stat.last) |=> !stat.active)
        else $error("line still active after end point");

    // a pixel comes only from a step word on an active line
    a_pixel_src: assert property (@(posedge clk) disable iff (!rst_n)
        stat.valid |-> (s1_ctrl.valid && stat.active
                        && s1_ctrl.action == blr_pkg::ACT_STEP))
        else $error("pixel without an active step");

    // a stalled result register blocks the input register from advancing
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && s1_ctrl.valid) |=> s1_ctrl.valid)
        else $error("held word lost during output stall");

endmodule
